// ===== design/uart8n1_pkg.sv =====
// Package with shared types and constants of the 8N1 serial transceiver.
`timescale 1ns / 1ps

package uart8n1_pkg;

	localparam int unsigned DATA_BITS = 8;
	localparam int unsigned PERIOD_W  = 16;
	localparam int unsigned INDEX_W   = 4;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd104;

	// Transmit frame positions: start bit, first data bit, last shifted and last data bit, stop bit, done.
	localparam logic [INDEX_W-1:0] TX_IDX_START     = 4'd0;
	localparam logic [INDEX_W-1:0] TX_IDX_FIRST     = 4'd1;
	localparam logic [INDEX_W-1:0] TX_IDX_LAST_SHIFT = 4'd7;
	localparam logic [INDEX_W-1:0] TX_IDX_LAST_DATA = 4'd8;
	localparam logic [INDEX_W-1:0] TX_IDX_STOP      = 4'd9;
	localparam logic [INDEX_W-1:0] TX_IDX_DONE      = 4'd10;

	// Receive positions: half-period wait, then the data bits.
	localparam logic [INDEX_W-1:0] RX_IDX_HALF  = 4'd0;
	localparam logic [INDEX_W-1:0] RX_IDX_FIRST = 4'd1;
	localparam logic [INDEX_W-1:0] RX_IDX_LAST  = 4'd8;

	typedef struct packed {
		logic                 tx_level;
		logic                 tx_busy;
		logic                 recv_valid;
		logic [DATA_BITS-1:0] recv_byte;
	} result_t;

endpackage

// ===== design/uart_transceiver_8n1.sv =====
// Top level of the 8N1 serial transceiver: tick-driven transmitter and receiver.
// Throughput: one request per cycle while in_stall is low; the bit timers are plain
// counters updated on each accept. The result for an accepted request is registered.
// An output register plus one skid entry let a request be taken while a result waits.
// Reset (arst_n low, asynchronous) idles both directions, sets the bit period to 104
// ticks, marks the receive line as high and empties the output stage.
`timescale 1ns / 1ps

module uart_transceiver_8n1 (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration: bit period in ticks.
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,

	// Request channel: one timebase tick.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        rx_level,
	input  logic        send_valid,
	input  logic [7:0]  send_byte,

	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_level,
	output logic        tx_busy,
	output logic        recv_valid,
	output logic [7:0]  recv_byte
);

	localparam int unsigned PW = uart8n1_pkg::PERIOD_W;
	localparam int unsigned IW = uart8n1_pkg::INDEX_W;
	localparam int unsigned DW = uart8n1_pkg::DATA_BITS;

	// Configuration register.
	logic [PW-1:0] bit_period_q;

	// Transmitter state.
	logic          tx_active_q;
	logic [DW-1:0] tx_shift_q;
	logic [IW-1:0] tx_bit_q;
	logic [PW-1:0] tx_timer_q;

	// Receiver state.
	logic          rx_active_q;
	logic [DW-1:0] rx_shift_q;
	logic [IW-1:0] rx_bit_q;
	logic [PW-1:0] rx_timer_q;
	logic          rx_prev_q;

	// Output register and skid entry.
	logic                  out_v_q;
	uart8n1_pkg::result_t  out_q;
	logic                  skid_v_q;
	uart8n1_pkg::result_t  skid_q;

	// Next-state values for one tick.
	logic          tx_active_d;
	logic [DW-1:0] tx_shift_d;
	logic [IW-1:0] tx_bit_d;
	logic [PW-1:0] tx_timer_d;
	logic          rx_active_d;
	logic [DW-1:0] rx_shift_d;
	logic [IW-1:0] rx_bit_d;
	logic [PW-1:0] rx_timer_d;
	logic          tx_level_d;
	logic          recv_valid_d;
	logic [DW-1:0] recv_byte_d;
	uart8n1_pkg::result_t res_d;

	logic [PW-1:0] period;
	logic [PW:0]   tx_count;
	logic [PW:0]   rx_count;
	logic [PW:0]   rx_target;
	logic          accept;
	logic          take;

	// A zero period behaves as a period of one tick.
	assign period = (bit_period_q == '0) ? {{(PW-1){1'b0}}, 1'b1} : bit_period_q;

	assign tx_count  = {1'b0, tx_timer_q} + {{PW{1'b0}}, 1'b1};
	assign rx_count  = {1'b0, rx_timer_q} + {{PW{1'b0}}, 1'b1};
	// The first wait after the falling edge is half a period, so sampling lands mid-bit.
	assign rx_target = (rx_bit_q == uart8n1_pkg::RX_IDX_HALF) ?
		{2'b00, period[PW-1:1]} : {1'b0, period};

	// Transmitter: advance the current bit, then pick up a new byte if idle.
	always_comb begin
		tx_active_d = tx_active_q;
		tx_shift_d  = tx_shift_q;
		tx_bit_d    = tx_bit_q;
		tx_timer_d  = tx_timer_q;
		if (tx_active_q) begin
			if (tx_count >= {1'b0, period}) begin
				tx_timer_d = '0;
				// The shift register holds the bit on the line in bit 0.
				if (tx_bit_q >= uart8n1_pkg::TX_IDX_FIRST &&
				    tx_bit_q <= uart8n1_pkg::TX_IDX_LAST_SHIFT) begin
					tx_shift_d = tx_shift_q >> 1;
				end
				tx_bit_d = tx_bit_q + {{(IW-1){1'b0}}, 1'b1};
				if (tx_bit_d >= uart8n1_pkg::TX_IDX_DONE) begin
					tx_active_d = 1'b0;
					tx_bit_d    = uart8n1_pkg::TX_IDX_START;
				end
			end else begin
				tx_timer_d = tx_count[PW-1:0];
			end
		end
		// The tick that ends the stop bit may already start the next frame.
		if (!tx_active_d && send_valid) begin
			tx_active_d = 1'b1;
			tx_shift_d  = send_byte;
			tx_bit_d    = uart8n1_pkg::TX_IDX_START;
			tx_timer_d  = '0;
		end
	end

	// Receiver: wait half a period after the edge, then sample one bit per period.
	always_comb begin
		rx_active_d = rx_active_q;
		rx_shift_d  = rx_shift_q;
		rx_bit_d    = rx_bit_q;
		rx_timer_d  = rx_timer_q;
		recv_valid_d = 1'b0;
		recv_byte_d  = '0;
		if (rx_active_q) begin
			if (rx_count >= rx_target) begin
				rx_timer_d = '0;
				if (rx_bit_q >= uart8n1_pkg::RX_IDX_FIRST) begin
					rx_shift_d = {rx_level, rx_shift_q[DW-1:1]};
					if (rx_bit_q >= uart8n1_pkg::RX_IDX_LAST) begin
						recv_valid_d = 1'b1;
						recv_byte_d  = rx_shift_d;
						rx_active_d  = 1'b0;
						rx_bit_d     = uart8n1_pkg::RX_IDX_HALF;
					end else begin
						rx_bit_d = rx_bit_q + {{(IW-1){1'b0}}, 1'b1};
					end
				end else begin
					rx_bit_d = uart8n1_pkg::RX_IDX_FIRST;
				end
			end else begin
				rx_timer_d = rx_count[PW-1:0];
			end
		end else if (rx_prev_q && !rx_level) begin
			// Falling edge while idle: the start bit begins.
			rx_active_d = 1'b1;
			rx_bit_d    = uart8n1_pkg::RX_IDX_HALF;
			rx_timer_d  = '0;
		end
	end

	// Transmit line level after this tick; the stop bit and idle line are high.
	always_comb begin
		tx_level_d = 1'b1;
		if (tx_active_d) begin
			if (tx_bit_d == uart8n1_pkg::TX_IDX_START) begin
				tx_level_d = 1'b0;
			end else if (tx_bit_d <= uart8n1_pkg::TX_IDX_LAST_DATA) begin
				tx_level_d = tx_shift_d[0];
			end
		end
	end

	assign res_d = '{tx_level: tx_level_d, tx_busy: tx_active_d,
		recv_valid: recv_valid_d, recv_byte: recv_byte_d};

	// Handshake: a request is refused only while the skid entry is occupied.
	assign in_stall = skid_v_q;
	assign accept   = in_valid && !in_stall;
	assign take     = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= uart8n1_pkg::PERIOD_RESET;
		end else if (cfg_wr_en) begin
			bit_period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_active_q <= 1'b0;
			tx_shift_q  <= '0;
			tx_bit_q    <= uart8n1_pkg::TX_IDX_START;
			tx_timer_q  <= '0;
			rx_active_q <= 1'b0;
			rx_shift_q  <= '0;
			rx_bit_q    <= uart8n1_pkg::RX_IDX_HALF;
			rx_timer_q  <= '0;
			rx_prev_q   <= 1'b1;
		end else if (accept) begin
			tx_active_q <= tx_active_d;
			tx_shift_q  <= tx_shift_d;
			tx_bit_q    <= tx_bit_d;
			tx_timer_q  <= tx_timer_d;
			rx_active_q <= rx_active_d;
			rx_shift_q  <= rx_shift_d;
			rx_bit_q    <= rx_bit_d;
			rx_timer_q  <= rx_timer_d;
			rx_prev_q   <= rx_level;
		end
	end

	// Output stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take || !out_v_q) begin
			out_v_q  <= skid_v_q || accept;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	// Output stage payload; an older result in the skid entry always goes first.
	always_ff @(posedge clk) begin
		if (take || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res_d;
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

	assign out_valid  = out_v_q;
	assign tx_level   = out_q.tx_level;
	assign tx_busy    = out_q.tx_busy;
	assign recv_valid = out_q.recv_valid;
	assign recv_byte  = out_q.recv_byte;

`ifndef SYNTH
	// The skid entry only fills behind a held result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid while output register empty");

	// The transmitter never runs past its stop bit.
	a_tx_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx_bit_q <= uart8n1_pkg::TX_IDX_STOP)
		else $error("transmit bit index out of range");

	// The receiver never runs past its last data bit.
	a_rx_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_bit_q <= uart8n1_pkg::RX_IDX_LAST)
		else $error("receive bit index out of range");

	// An idle transmitter sits at the start of a frame with a cleared timer.
	a_tx_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!tx_active_q |-> (tx_bit_q == uart8n1_pkg::TX_IDX_START && tx_timer_q == '0))
		else $error("idle transmitter holds stale position");

	// A result reporting an idle transmitter must show a high line.
	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_q.tx_busy) |-> out_q.tx_level)
		else $error("transmit line low while transmitter idle");
`endif

endmodule

// ===== tb/tb_uart_transceiver_8n1.sv =====
// Self-checking 8N1 serial transceiver testbench: random and directed ticks against a predictor.
`timescale 1ns / 1ps

module tb_uart_transceiver_8n1;

	localparam int unsigned PW = uart8n1_pkg::PERIOD_W;
	localparam int unsigned DW = uart8n1_pkg::DATA_BITS;
	localparam int unsigned IW = uart8n1_pkg::INDEX_W;

	// A watchdog ends the run when this many cycles pass with no request or result moving.
	localparam int unsigned QUIET_LIMIT = 5000;
	// Extra cycles waited after the last result has come back.
	localparam int unsigned SETTLE_CYCLES = 8;
	// Share of random ticks that offer a byte to the transmitter.
	localparam int unsigned SEND_PCT = 40;

	// The scoreboard carries its own copy of the transceiver state. Every accepted request
	// advances that copy by one tick, and the predicted result joins a queue in order.
	// Each result from the block is compared with the oldest prediction, field by field.
	class uart_tick_scoreboard;
		logic [PW-1:0]         bit_ticks;
		logic                  tx_on;
		logic [DW-1:0]         tx_sr;
		logic [IW-1:0]         tx_pos;
		logic [PW-1:0]         tx_cnt;
		logic                  rx_on;
		logic [DW-1:0]         rx_sr;
		logic [IW-1:0]         rx_pos;
		logic [PW-1:0]         rx_cnt;
		logic                  rx_prev;
		uart8n1_pkg::result_t  expected_ticks[$];
		int unsigned           mismatches;
		int unsigned           checked;

		function new();
			bit_ticks = uart8n1_pkg::PERIOD_RESET;
			tx_on = 1'b0;
			tx_sr = '0;
			tx_pos = uart8n1_pkg::TX_IDX_START;
			tx_cnt = '0;
			rx_on = 1'b0;
			rx_sr = '0;
			rx_pos = uart8n1_pkg::RX_IDX_HALF;
			rx_cnt = '0;
			rx_prev = 1'b1;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_period(logic [PW-1:0] ticks);
			bit_ticks = ticks;
		endfunction

		function int unsigned outstanding();
			return expected_ticks.size();
		endfunction

		function void predict_tick(logic rx, logic offer, logic [DW-1:0] data);
			int unsigned per;
			int unsigned t;
			int unsigned target;
			uart8n1_pkg::result_t r;
			per = (bit_ticks == '0) ? 32'd1 : 32'(bit_ticks);
			r = '0;
			r.tx_level = 1'b1;

			// Transmitter: advance the running frame, then maybe take a new byte.
			if (tx_on) begin
				t = 32'(tx_cnt) + 32'd1;
				if (t >= per) begin
					tx_cnt = '0;
					if (tx_pos >= uart8n1_pkg::TX_IDX_FIRST &&
					    tx_pos <= uart8n1_pkg::TX_IDX_LAST_SHIFT)
						tx_sr = tx_sr >> 1;
					tx_pos = tx_pos + 1'b1;
					if (tx_pos >= uart8n1_pkg::TX_IDX_DONE) begin
						tx_on = 1'b0;
						tx_pos = uart8n1_pkg::TX_IDX_START;
					end
				end else begin
					tx_cnt = t[PW-1:0];
				end
			end
			if (!tx_on && offer) begin
				tx_on = 1'b1;
				tx_sr = data;
				tx_pos = uart8n1_pkg::TX_IDX_START;
				tx_cnt = '0;
			end
			if (tx_on) begin
				if (tx_pos == uart8n1_pkg::TX_IDX_START)
					r.tx_level = 1'b0;
				else if (tx_pos <= uart8n1_pkg::TX_IDX_LAST_DATA)
					r.tx_level = tx_sr[0];
				else
					r.tx_level = 1'b1;
			end
			r.tx_busy = tx_on;

			// Receiver: half-period wait, then eight samples one period apart.
			if (rx_on) begin
				t = 32'(rx_cnt) + 32'd1;
				target = (rx_pos == uart8n1_pkg::RX_IDX_HALF) ? (per >> 1) : per;
				if (t >= target) begin
					rx_cnt = '0;
					if (rx_pos >= uart8n1_pkg::RX_IDX_FIRST) begin
						rx_sr = {rx, rx_sr[DW-1:1]};
						if (rx_pos >= uart8n1_pkg::RX_IDX_LAST) begin
							r.recv_valid = 1'b1;
							r.recv_byte = rx_sr;
							rx_on = 1'b0;
							rx_pos = uart8n1_pkg::RX_IDX_HALF;
						end else begin
							rx_pos = rx_pos + 1'b1;
						end
					end else begin
						rx_pos = uart8n1_pkg::RX_IDX_FIRST;
					end
				end else begin
					rx_cnt = t[PW-1:0];
				end
			end else if (rx_prev && !rx) begin
				rx_on = 1'b1;
				rx_pos = uart8n1_pkg::RX_IDX_HALF;
				rx_cnt = '0;
			end
			rx_prev = rx;
			expected_ticks.push_back(r);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 30)
				$display("[%0t] check failed on result %0d: %s", $time, checked, what);
		endtask

		task check_tick(logic tx_lvl, logic busy, logic rv, logic [DW-1:0] rb);
			uart8n1_pkg::result_t want;
			if (expected_ticks.size() == 0) begin
				report("result with no request waiting for it");
				return;
			end
			want = expected_ticks.pop_front();
			if (tx_lvl !== want.tx_level)
				report($sformatf("tx_level got %b want %b", tx_lvl, want.tx_level));
			if (busy !== want.tx_busy)
				report($sformatf("tx_busy got %b want %b", busy, want.tx_busy));
			if (rv !== want.recv_valid)
				report($sformatf("recv_valid got %b want %b", rv, want.recv_valid));
			if (rb !== want.recv_byte)
				report($sformatf("recv_byte got %h want %h", rb, want.recv_byte));
			checked++;
		endtask
	endclass

	logic          clk;
	logic          arst_n = 1'b0;
	logic          cfg_wr_en = 1'b0;
	logic [PW-1:0] cfg_wr_data = '0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic          rx_level = 1'b1;
	logic          send_valid = 1'b0;
	logic [DW-1:0] send_byte = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic          tx_level;
	logic          tx_busy;
	logic          recv_valid;
	logic [DW-1:0] recv_byte;

	uart_tick_scoreboard sb = new();

	// Percent chance per cycle that the request side holds back or the result side stalls.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// The receive line is planned as runs of one level, each lasting a number of ticks.
	// Runs are consumed one tick per request, so even the longest bit period needs only one entry per run.
	logic        line_lvl[$];
	int unsigned line_len[$];

	uart_transceiver_8n1 u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_level    (rx_level),
		.send_valid  (send_valid),
		.send_byte   (send_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tx_level    (tx_level),
		.tx_busy     (tx_busy),
		.recv_valid  (recv_valid),
		.recv_byte   (recv_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor for both channels. All block outputs and all driven inputs change only through
	// nonblocking updates, so at the edge this block sees the values that the edge samples.
	// A request is noted before a result is checked; a result never belongs to a request
	// taken at the same edge, so the order between the two is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.predict_tick(rx_level, send_valid, send_byte);
			if (out_valid && !out_stall)
				sb.check_tick(tx_level, tx_busy, recv_valid, recv_byte);
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog: counts cycles in which neither channel moves. Reset does not count as quiet.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void queue_run(logic lvl, int unsigned len);
		if (len != 0) begin
			line_lvl.push_back(lvl);
			line_len.push_back(len);
		end
	endfunction

	// Most traffic on the receive line is well-formed frames with random data and random
	// idle gaps, so the receiver gets through every bit. The rest is noise: random short
	// runs, short low pulses that look like start bits, and now and then a low stop bit.
	function automatic void plan_traffic(int unsigned per);
		logic [DW-1:0] data;
		int unsigned pick;
		data = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 75) begin
			queue_run(1'b1, $urandom_range(3 * per));
			queue_run(1'b0, per);
			for (int unsigned b = 0; b < DW; b++)
				queue_run(data[b], per);
			queue_run((pick < 8) ? 1'b0 : 1'b1, per);
		end else if (pick < 90) begin
			for (int n = 0; n < 6; n++)
				queue_run(1'($urandom_range(1)), $urandom_range(per, 1));
		end else begin
			queue_run(1'b1, 1);
			queue_run(1'b0, $urandom_range(per, 1));
			queue_run(1'b1, per);
		end
	endfunction

	function automatic logic next_rx_level(int unsigned per);
		logic lvl;
		if (line_len.size() == 0)
			plan_traffic(per);
		lvl = line_lvl[0];
		if (line_len[0] <= 1) begin
			void'(line_lvl.pop_front());
			void'(line_len.pop_front());
		end else begin
			line_len[0] = line_len[0] - 1;
		end
		return lvl;
	endfunction

	// Offer one tick and hold it until it is taken. Valid is raised with the payload and is
	// left high on return, so back-to-back requests never lower and raise it in one step.
	task automatic offer_tick(logic rx, logic offer, logic [DW-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_level <= rx;
		send_valid <= offer;
		send_byte <= data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has come back. The queue is
	// polled on the falling edge, when the monitor has finished with the rising one;
	// the task then returns on a rising edge so that driving resumes there.
	task automatic drain_results(int unsigned settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(negedge clk);
		@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Only called with the request side drained, so the new period applies from the next
	// request on, in the block and in the scoreboard alike. Old line plans are dropped.
	task automatic write_period(logic [PW-1:0] ticks);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ticks;
		sb.set_period(ticks);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		line_lvl.delete();
		line_len.delete();
	endtask

	task automatic run_random(int unsigned per, int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			// Now and then the sender pauses until the block has nothing left in flight.
			if ($urandom_range(63) == 0)
				drain_results(0);
			offer_tick(next_rx_level(per), ($urandom_range(99) < SEND_PCT),
				8'($urandom_range(255)));
		end
	endtask

	// Directed ticks at a period of two. The transmitter takes 0xFF, ignores offers while
	// busy, sends the last stop-bit tick on tick 19 and takes 0x00 on tick 20, the very tick
	// it goes idle. The receive line falls on tick 1 and stays low for a byte of zeros, with
	// a one-tick high glitch whose falling edge lands mid-reception and must be ignored.
	task automatic run_directed();
		logic          rx;
		logic          offer;
		logic [DW-1:0] data;
		for (int k = 0; k < 25; k++) begin
			rx = !(k >= 1 && k <= 18 && k != 5);
			offer = (k <= 3) || (k == 20);
			data = (k == 0) ? 8'hFF : (k == 20) ? 8'h00 : 8'h5A;
			offer_tick(rx, offer, data);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one: sender idles lightly, receiver stalls often. Start at the reset period.
		send_idle_pct = 18;
		recv_stall_pct = 73;
		run_random(32'(uart8n1_pkg::PERIOD_RESET), 40);

		drain_results(SETTLE_CYCLES);
		write_period(16'd2);
		run_directed();
		run_random(2, 150);

		// Phase two: the other way round. The longest period only gets far enough to see
		// start bits and the receiver's half-period wait in progress.
		drain_results(SETTLE_CYCLES);
		send_idle_pct = 73;
		recv_stall_pct = 18;
		write_period(16'hFFFF);
		run_random(32'hFFFF, 40);

		drain_results(SETTLE_CYCLES);
		write_period(16'd3);
		run_random(3, 120);

		// Phase three: full rate on both sides.
		drain_results(SETTLE_CYCLES);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_period(16'd5);
		run_random(5, 120);

		drain_results(SETTLE_CYCLES);
		write_period(16'd2);
		run_random(2, 80);

		drain_results(SETTLE_CYCLES);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
